>>> hdl/fdcm_pkg.sv
package fdcm_pkg;

  // Coordinate and register widths fixed by the item layout.
  localparam int CoordBits   = 10;
  localparam int FracBitsDef = 16;
  localparam int SizeW       = 11;
  localparam int LensW       = 10;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 11;

  // Register reset values.
  localparam logic [SizeW-1:0] ResetOutWidth  = SizeW'(1000);
  localparam logic [SizeW-1:0] ResetOutHeight = SizeW'(1000);
  localparam logic [SizeW-1:0] ResetSrcWidth  = SizeW'(717);
  localparam logic [SizeW-1:0] ResetSrcHeight = SizeW'(717);
  localparam logic [LensW-1:0] ResetLens      = LensW'(350);

  typedef enum logic [CfgIdxW-1:0] {
    CfgOutWidth,
    CfgOutHeight,
    CfgSrcWidth,
    CfgSrcHeight,
    CfgLensRadius
  } cfg_idx_e;

  // Offset magnitude, squared radius and root widths.
  localparam int MagW     = (CoordBits > SizeW - 1) ? CoordBits : SizeW - 1;
  localparam int OffW     = MagW + 1;
  localparam int S2W      = 2 * MagW + 1;
  localparam int DiagW    = 2 * SizeW + 1;
  localparam int RootFrac = 8;
  localparam int RootInR  = S2W + 2 * RootFrac;
  localparam int RootInD  = DiagW + 2 * RootFrac;
  localparam int RootW    = ((RootInR > RootInD ? RootInR : RootInD) + 1) / 2;
  localparam int SqInW    = 2 * RootW;

  // Quarter-wave sine polynomial coefficients in Q30.
  localparam logic [30:0] SinC1 = 31'd1686629713;
  localparam logic [30:0] SinC3 = 31'd693598668;
  localparam logic [30:0] SinC5 = 31'd85569306;
  localparam logic [30:0] SinC7 = 31'd5026995;
  localparam logic [30:0] SinC9 = 31'd172272;

  typedef struct packed {
    logic [CoordBits-1:0] out_x;
    logic [CoordBits-1:0] out_y;
  } fdcm_in_t;

  typedef struct packed {
    logic [CoordBits-1:0] src_x;
    logic [CoordBits-1:0] src_y;
    logic                 clamped;
  } fdcm_out_t;

endpackage

>>> hdl/fdcm_pdiv.sv
module fdcm_pdiv #(
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int QW    = 8,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [LANES-1:0][DW-1:0]   rem_o,
  output logic [SW-1:0]              side_o
);

  // Restoring divider, one quotient bit per stage for every lane. Only the
  // low QW quotient bits are kept.
  logic [NW-1:0]                   v_q;
  logic [LANES-1:0][NW-1:0]        num_q [NW-1];
  logic [LANES-1:0][DW-1:0]        rem_q [NW];
  logic [LANES-1:0][QW-1:0]        quo_q [NW];
  logic [DW-1:0]                   den_q [NW];
  logic [SW-1:0]                   side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic                     pv;
    logic [LANES-1:0][NW-1:0] pn;
    logic [LANES-1:0][DW-1:0] pr;
    logic [LANES-1:0][QW-1:0] pq;
    logic [DW-1:0]            pd;
    logic [SW-1:0]            ps;
    logic [LANES-1:0][NW-1:0] nn;
    logic [LANES-1:0][DW-1:0] nr;
    logic [LANES-1:0][QW-1:0] nq;

    if (k == 0) begin : g_first
      assign pv = valid_i;
      assign pn = num_i;
      assign pr = '0;
      assign pq = '0;
      assign pd = den_i;
      assign ps = side_i;
    end else begin : g_next
      assign pv = v_q[k-1];
      assign pn = num_q[k-1];
      assign pr = rem_q[k-1];
      assign pq = quo_q[k-1];
      assign pd = den_q[k-1];
      assign ps = side_q[k-1];
    end

    always_comb begin
      logic [DW:0] trial;
      logic        qbit;
      trial = '0;
      qbit  = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        trial = {pr[l], pn[l][NW-1]};
        qbit  = (trial >= {1'b0, pd});
        if (qbit) begin
          nr[l] = DW'(trial - {1'b0, pd});
        end else begin
          nr[l] = trial[DW-1:0];
        end
        nq[l] = QW'({pq[l], qbit});
        nn[l] = pn[l] << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= nr;
      quo_q[k]  <= nq;
      den_q[k]  <= pd;
      side_q[k] <= ps;
    end

    if (k < NW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        num_q[k] <= nn;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign side_o  = side_q[NW-1];

  // A finished remainder is always below a nonzero divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NW-1] && den_q[NW-1] != '0) |->
      (rem_q[NW-1][0] < den_q[NW-1] && rem_q[NW-1][LANES-1] < den_q[NW-1]))
    else $error("divider remainder not below divisor");

  // Every item that enters comes out again at the end of the divider.
  a_valid_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##NW valid_o)
    else $error("divider dropped an item");

  // Nothing comes out that did not enter the divider before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, NW))
    else $error("divider produced an item from nowhere");

endmodule

>>> hdl/fisheye_dewarp_coordinate_map.sv
// Channel   Direction  Handshake               Payload
// -------   ---------  ---------               -------
// item      in         start && !busy          item_i  (out_x, out_y)
// result    out        done_o, one cycle       result_o (src_x, src_y, clamped)
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item enters per clock; busy stays low and start may be held high.
// The stages, in order: centre offset, squared radius, the square roots of
// width RootW (20), the angle divider, the sine, the multipliers, the final
// divider of width NW2 (29) and the result register. The two dividers set the depth.
// Reset clears every valid bit and loads the register defaults.
// The result strobe cannot be stalled, so the pipeline never stops.
module fisheye_dewarp_coordinate_map #(
  parameter int FRAC_BITS = fdcm_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  fdcm_pkg::fdcm_in_t              item_i,
  output logic                            done_o,
  output fdcm_pkg::fdcm_out_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [fdcm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fdcm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fdcm_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int TNW   = RootW + 1 + F;      // numerator of the angle ratio
  localparam int TQW   = F + 2;              // ratio kept modulo four
  localparam int SqW   = F + 1;              // sine, up to 1.0
  localparam int A1W   = LensW + SqW;
  localparam int AW    = A1W + MagW;
  localparam int LowW  = F - 8;              // bits dropped before the divide
  localparam int NW2   = AW - LowW;
  localparam int VW    = NW2 + 2;
  localparam int RemW  = RootW + 3;

  localparam logic [30:0] HornerC [4] = '{SinC7, SinC5, SinC3, SinC1};

  typedef struct packed {
    logic [MagW-1:0] mb;
    logic [MagW-1:0] ma;
    logic            nb;
    logic            na;
    logic            zero;
  } geo_t;

  typedef struct packed {
    geo_t             geo;
    logic [RootW-1:0] r8;
  } tside_t;

  typedef struct packed {
    geo_t             geo;
    logic [RootW-1:0] r8;
    logic             sneg;
  } sside_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic lnzx;
    logic lnzy;
    logic zero;
  } xside_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } isq_t;

  typedef struct packed {
    logic                 hit;
    logic [CoordBits-1:0] val;
  } coord_t;

  // One step of the digit-by-digit floor square root.
  function automatic isq_t isq_step(input logic [RemW-1:0] rem,
                                    input logic [RootW-1:0] root,
                                    input logic [1:0] pair);
    logic [RemW-1:0] rs;
    logic [RemW-1:0] trial;
    isq_t            res;
    rs    = {rem[RemW-3:0], pair};
    trial = RemW'({root, 2'b01});
    if (rs >= trial) begin
      res.rem  = rs - trial;
      res.root = {root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = rs;
      res.root = {root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

  // One Horner step: c - x2 * acc, floored and kept at zero or above.
  function automatic logic [30:0] sin_step(input logic [30:0] c,
                                           input logic [30:0] x2,
                                           input logic [30:0] acc);
    logic [61:0] prod;
    logic [31:0] sh;
    prod = 62'(x2) * 62'(acc);
    sh   = 32'(prod >> 30);
    if (sh > 32'(c)) begin
      return '0;
    end
    return 31'(32'(c) - sh);
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [OffW-1:0] v);
    if (v[OffW-1]) begin
      return MagW'(-v);
    end
    return MagW'(v);
  endfunction

  // Centre plus the signed quotient, truncated toward zero, then clamped.
  function automatic coord_t map_coord(input logic [SizeW-2:0] c,
                                       input logic [NW2-1:0] q,
                                       input logic rnz,
                                       input logic neg,
                                       input logic zero,
                                       input logic [SizeW-1:0] size);
    logic signed [VW-1:0] cv;
    logic signed [VW-1:0] qv;
    logic signed [VW-1:0] sz;
    logic signed [VW-1:0] v;
    coord_t               res;
    cv      = VW'(c);
    qv      = VW'(q);
    sz      = VW'(size);
    res.hit = 1'b0;
    if (zero) begin
      v = cv;
    end else if (!neg) begin
      v = cv + qv;
    end else if (rnz && (cv > qv)) begin
      v = cv - qv - VW'(1);
    end else begin
      v = cv - qv;
    end
    if (v >= sz) begin
      v       = sz - VW'(1);
      res.hit = 1'b1;
    end
    if (v < 0) begin
      v       = '0;
      res.hit = 1'b1;
    end
    res.val = v[CoordBits-1:0];
    return res;
  endfunction

  // Configuration registers.
  logic [SizeW-1:0] out_w_q, out_h_q, src_w_q, src_h_q;
  logic [LensW-1:0] lens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_w_q <= ResetOutWidth;
      out_h_q <= ResetOutHeight;
      src_w_q <= ResetSrcWidth;
      src_h_q <= ResetSrcHeight;
      lens_q  <= ResetLens;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOutWidth:   out_w_q <= cfg_data_i[SizeW-1:0];
        CfgOutHeight:  out_h_q <= cfg_data_i[SizeW-1:0];
        CfgSrcWidth:   src_w_q <= cfg_data_i[SizeW-1:0];
        CfgSrcHeight:  src_h_q <= cfg_data_i[SizeW-1:0];
        CfgLensRadius: lens_q  <= cfg_data_i[LensW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never waits, so the block is always ready for an item.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: offset from the output centre.
  logic                   v1_q;
  logic signed [OffW-1:0] b1_q, a1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q <= $signed(OffW'(item_i.out_x)) - $signed(OffW'(out_w_q[SizeW-1:1]));
    a1_q <= $signed(OffW'(item_i.out_y)) - $signed(OffW'(out_h_q[SizeW-1:1]));
  end

  // Stage 2: squared radius and squared diagonal.
  logic             v2_q;
  logic [S2W-1:0]   s2_q;
  logic [DiagW-1:0] diag2_q;
  geo_t             geo2_q;
  logic [MagW-1:0]  mb1, ma1;

  assign mb1 = mag(b1_q);
  assign ma1 = mag(a1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q    <= S2W'(mb1) * S2W'(mb1) + S2W'(ma1) * S2W'(ma1);
    diag2_q <= DiagW'(out_w_q) * DiagW'(out_w_q) + DiagW'(out_h_q) * DiagW'(out_h_q);
    geo2_q  <= '{mb: mb1, ma: ma1, nb: b1_q[OffW-1], na: a1_q[OffW-1],
                 zero: (mb1 == '0) && (ma1 == '0)};
  end

  // Two square roots side by side, one result bit per stage: r and the
  // full diagonal, both in Q8.
  logic [RootW-1:0] iv_q;
  logic [SqInW-1:0] rin_q [RootW-1];
  logic [SqInW-1:0] din_q [RootW-1];
  isq_t             rr_q  [RootW];
  isq_t             dr_q  [RootW];
  geo_t             igeo_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_isq
    logic             pv;
    logic [SqInW-1:0] pr, pd;
    isq_t             psr, psd;
    geo_t             pg;

    if (k == 0) begin : g_first
      assign pv  = v2_q;
      assign pr  = SqInW'(s2_q) << (2 * RootFrac);
      assign pd  = SqInW'(diag2_q) << (2 * RootFrac);
      assign psr = '0;
      assign psd = '0;
      assign pg  = geo2_q;
    end else begin : g_next
      assign pv  = iv_q[k-1];
      assign pr  = rin_q[k-1];
      assign pd  = din_q[k-1];
      assign psr = rr_q[k-1];
      assign psd = dr_q[k-1];
      assign pg  = igeo_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        iv_q[k] <= 1'b0;
      end else begin
        iv_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      rr_q[k]   <= isq_step(psr.rem, psr.root, pr[SqInW-1 -: 2]);
      dr_q[k]   <= isq_step(psd.rem, psd.root, pd[SqInW-1 -: 2]);
      igeo_q[k] <= pg;
    end

    if (k < RootW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rin_q[k] <= pr << 2;
        din_q[k] <= pd << 2;
      end
    end
  end

  // Angle ratio t = 2*r8 / d8 in Q F; a zero diagonal divides by one.
  logic [RootW-1:0]        r8, d8;
  logic [TNW-1:0]          tnum;
  tside_t                  tside_in;
  logic                    tv;
  logic [TQW-1:0]          tq;
  logic [$bits(tside_t)-1:0] tside_raw;
  tside_t                  tside;

  assign r8       = rr_q[RootW-1].root;
  assign d8       = (dr_q[RootW-1].root == '0) ? RootW'(1) : dr_q[RootW-1].root;
  assign tnum     = TNW'({r8, 1'b0}) << F;
  assign tside_in = '{geo: igeo_q[RootW-1], r8: r8};
  assign tside    = tside_t'(tside_raw);

  fdcm_pdiv #(
    .NW   (TNW),
    .DW   (RootW),
    .QW   (TQW),
    .LANES(1),
    .SW   ($bits(tside_t))
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(iv_q[RootW-1]),
    .num_i  (tnum),
    .den_i  (d8),
    .side_i (tside_in),
    .valid_o(tv),
    .quo_o  (tq),
    .rem_o  (),
    .side_o (tside_raw)
  );

  // Sine of (pi/2)*t: the quadrant folds t onto [0, 1], then x^2 and four
  // Horner steps, each behind its own register, and a final multiply by x.
  logic [1:0]     quad;
  logic [F-1:0]   frac;
  logic [SqW-1:0] xq;
  logic [30:0]    x30_d;

  assign quad  = tq[F+1:F];
  assign frac  = tq[F-1:0];
  assign xq    = quad[0] ? ((SqW'(1) << F) - SqW'(frac)) : SqW'(frac);
  assign x30_d = 31'(xq) << (30 - F);

  logic [5:0]  sv_q;
  logic [30:0] x30_q [5];
  logic [30:0] x2_q  [4];
  logic [30:0] acc_q [4];
  sside_t      ss_q  [6];
  logic [SqW-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= tv;
    end
  end

  always_ff @(posedge clk_i) begin
    x30_q[0] <= x30_d;
    x2_q[0]  <= 31'((62'(x30_d) * 62'(x30_d)) >> 30);
    ss_q[0]  <= '{geo: tside.geo, r8: tside.r8, sneg: quad[1]};
  end

  for (genvar k = 1; k < 5; k++) begin : g_horner
    logic [30:0] pacc;

    if (k == 1) begin : g_first
      assign pacc = SinC9;
    end else begin : g_next
      assign pacc = acc_q[k-2];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= sv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[k-1] <= sin_step(HornerC[k-1], x2_q[k-1], pacc);
      x30_q[k]   <= x30_q[k-1];
      ss_q[k]    <= ss_q[k-1];
    end

    if (k < 4) begin : g_keep
      always_ff @(posedge clk_i) begin
        x2_q[k] <= x2_q[k-1];
      end
    end
  end

  logic [61:0] sprod;
  logic [31:0] ssh;
  logic [31:0] scap;

  assign sprod = 62'(x30_q[4]) * 62'(acc_q[3]);
  assign ssh   = 32'(sprod >> 30);
  assign scap  = (ssh > (32'd1 << 30)) ? (32'd1 << 30) : ssh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[5] <= 1'b0;
    end else begin
      sv_q[5] <= sv_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q    <= SqW'(scap >> (30 - F));
    ss_q[5] <= ss_q[4];
  end

  // Magnitudes lens * sin * |offset|: lens * sin first, then both offsets together.
  logic           m1v_q, m2v_q;
  logic [A1W-1:0] m1_q;
  logic [AW-1:0]  ax_q, ay_q;
  sside_t         m1s_q, m2s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
    end else begin
      m1v_q <= sv_q[5];
      m2v_q <= m1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= A1W'(lens_q) * A1W'(sq_q);
    m1s_q <= ss_q[5];
    ax_q  <= AW'(m1_q) * AW'(m1s_q.geo.mb);
    ay_q  <= AW'(m1_q) * AW'(m1s_q.geo.ma);
    m2s_q <= m1s_q;
  end

  // Divide by r8 * 2^(F-8): the low F-8 bits of the scaled magnitude are
  // dropped first and remembered only as a nonzero remainder flag.
  logic [1:0][NW2-1:0]       xnum;
  xside_t                    xside_in;
  logic                      xyv;
  logic [1:0][NW2-1:0]       xyq;
  logic [1:0][RootW-1:0]     xyr;
  logic [$bits(xside_t)-1:0] xside_raw;
  xside_t                    xside;

  assign xnum[0]  = ax_q[AW-1:LowW];
  assign xnum[1]  = ay_q[AW-1:LowW];
  assign xside_in = '{negx: m2s_q.sneg ^ m2s_q.geo.nb,
                      negy: m2s_q.sneg ^ m2s_q.geo.na,
                      lnzx: |ax_q[LowW-1:0],
                      lnzy: |ay_q[LowW-1:0],
                      zero: m2s_q.geo.zero};
  assign xside    = xside_t'(xside_raw);

  fdcm_pdiv #(
    .NW   (NW2),
    .DW   (RootW),
    .QW   (NW2),
    .LANES(2),
    .SW   ($bits(xside_t))
  ) u_xydiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(m2v_q),
    .num_i  (xnum),
    .den_i  (m2s_q.r8),
    .side_i (xside_in),
    .valid_o(xyv),
    .quo_o  (xyq),
    .rem_o  (xyr),
    .side_o (xside_raw)
  );

  // Final stage: add to the source centre, truncate toward zero, clamp.
  coord_t cx, cy;

  assign cx = map_coord(src_w_q[SizeW-1:1], xyq[0], xside.lnzx || (xyr[0] != '0),
                        xside.negx, xside.zero, src_w_q);
  assign cy = map_coord(src_h_q[SizeW-1:1], xyq[1], xside.lnzy || (xyr[1] != '0),
                        xside.negy, xside.zero, src_h_q);

  logic      done_q;
  fdcm_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= xyv;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= '{src_x: cx.val, src_y: cy.val, clamped: cx.hit || cy.hit};
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // The sine never exceeds 1.0 after the cap.
  a_sine_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[5] |-> (sq_q <= (SqW'(1) << F)))
    else $error("sine above 1.0");

  // Every item leaving the multipliers comes out after the final divider and the result register.
  a_tail_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m2v_q |-> ##(NW2 + 1) done_q)
    else $error("result strobe out of step with the divider");

  // The pipeline never holds off an item.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy == 1'b0)
    else $error("busy raised");

endmodule

>>> test/fdcm_checker.sv
`timescale 1ns / 1ps

module fdcm_checker
  import fdcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  fdcm_in_t            item_i,
  input  logic                done_i,
  input  fdcm_out_t           result_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  localparam int Frac = FracBitsDef;

  longint    ow, oh, sw, sh, lens;
  fdcm_out_t src_coord_q[$];

  function automatic longint floor_sqrt(longint v);
    longint res;
    longint bitv;
    res  = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_to(longint v, longint size, inout bit hit);
    if (v >= size) begin
      v   = size - 1;
      hit = 1'b1;
    end
    if (v < 0) begin
      v   = 0;
      hit = 1'b1;
    end
    return v;
  endfunction

  function automatic fdcm_out_t map_to_source(fdcm_in_t it);
    longint    b, a, xc, yc, s2, r8, d8, t, p, quad, f, x, xq, x2, acc, sq;
    longint    den, magx, magy, px, py;
    bit        hit;
    fdcm_out_t res;
    hit = 1'b0;
    b   = longint'(it.out_x) - ow / 2;
    a   = longint'(it.out_y) - oh / 2;
    xc  = sw / 2;
    yc  = sh / 2;
    s2  = a * a + b * b;
    if (s2 == 0) begin
      // The centre pixel maps straight onto the source centre.
      px = xc;
      py = yc;
    end else begin
      r8 = floor_sqrt(s2 << 16);
      d8 = floor_sqrt((ow * ow + oh * oh) << 16);
      if (d8 == 0) d8 = 1;
      t    = ((2 * r8) << Frac) / d8;
      p    = t & ((longint'(4) << Frac) - 1);
      quad = p >> Frac;
      f    = p & ((longint'(1) << Frac) - 1);
      x    = quad[0] ? (longint'(1) << Frac) - f : f;
      xq   = x << (30 - Frac);
      x2   = (xq * xq) >>> 30;
      acc  = SinC9;
      acc  = SinC7 - ((x2 * acc) >>> 30); if (acc < 0) acc = 0;
      acc  = SinC5 - ((x2 * acc) >>> 30); if (acc < 0) acc = 0;
      acc  = SinC3 - ((x2 * acc) >>> 30); if (acc < 0) acc = 0;
      acc  = SinC1 - ((x2 * acc) >>> 30); if (acc < 0) acc = 0;
      acc  = (xq * acc) >>> 30;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      sq   = acc >>> (30 - Frac);
      den  = r8 << Frac;
      magx = lens * sq * (b < 0 ? -b : b) * 256;
      magy = lens * sq * (a < 0 ? -a : a) * 256;
      if (quad[1] != (b < 0)) magx = -magx;
      if (quad[1] != (a < 0)) magy = -magy;
      // SystemVerilog division already truncates toward zero.
      px = (xc * den + magx) / den;
      py = (yc * den + magy) / den;
    end
    px = clamp_to(px, sw, hit);
    py = clamp_to(py, sh, hit);
    res.src_x   = px[CoordBits-1:0];
    res.src_y   = py[CoordBits-1:0];
    res.clamped = hit;
    return res;
  endfunction

  assign pending_o = src_coord_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    fdcm_out_t want;
    int        bad;
    bad = 0;
    if (!rst_ni) begin
      ow       <= ResetOutWidth;
      oh       <= ResetOutHeight;
      sw       <= ResetSrcWidth;
      sh       <= ResetSrcHeight;
      lens     <= ResetLens;
      errors_o <= 0;
      src_coord_q.delete();
    end else begin
      if (start_i && !busy_i) src_coord_q.push_back(map_to_source(item_i));
      if (done_i) begin
        if (src_coord_q.size() == 0) begin
          $error("result with no item outstanding: %p", result_i);
          bad++;
        end else begin
          want = src_coord_q.pop_front();
          if (result_i.src_x !== want.src_x) begin
            $error("src_x: expected %0d, got %0d", want.src_x, result_i.src_x);
            bad++;
          end
          if (result_i.src_y !== want.src_y) begin
            $error("src_y: expected %0d, got %0d", want.src_y, result_i.src_y);
            bad++;
          end
          if (result_i.clamped !== want.clamped) begin
            $error("clamped: expected %0d, got %0d", want.clamped, result_i.clamped);
            bad++;
          end
        end
      end
      errors_o <= errors_o + bad;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgOutWidth:   ow   <= cfg_data_i;
          CfgOutHeight:  oh   <= cfg_data_i;
          CfgSrcWidth:   sw   <= cfg_data_i;
          CfgSrcHeight:  sh   <= cfg_data_i;
          CfgLensRadius: lens <= cfg_data_i[LensW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/fisheye_dewarp_coordinate_map_tb.sv
`timescale 1ns / 1ps

// Testbench for the fisheye coordinate map. Stimulus lives here; a checker
// beside the block predicts every source coordinate and compares results.
module fisheye_dewarp_coordinate_map_tb;
  import fdcm_pkg::*;

  // The pipeline drains well within QuietLimit, so a quiet stretch that long
  // can only mean the block has stopped answering.
  localparam int Drain      = 110;
  localparam int QuietLimit = 1000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fdcm_in_t            item;
  logic                done;
  fdcm_out_t           result;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  errors;
  int                  pending;
  int                  quiet_cycles;
  int                  sent;
  // Output image size currently loaded, used to aim most random pixels
  // inside the picture.
  int                  cur_ow, cur_oh;

  fisheye_dewarp_coordinate_map uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .item_i     (item),
    .done_o     (done),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fdcm_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .item_i     (item),
    .done_i     (done),
    .result_i   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one pixel and hold it until the block takes it. Start stays high
  // across back-to-back items; each following cycle idles at random unless
  // may_idle is clear, as for the directed pixels and the random no-idle stretch.
  task automatic send_pixel(input int x, input int y, input bit may_idle);
    int gap;
    start      <= 1'b1;
    item.out_x <= x[CoordBits-1:0];
    item.out_y <= y[CoordBits-1:0];
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    sent++;
    gap = 0;
    while (may_idle && $urandom_range(0, 99) < 34) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Registers change only with the pipeline empty: every item yields a
  // result, so an empty queue followed by the Drain wait is enough.
  task automatic load_geometry(input int ow, input int oh, input int sw, input int sh,
                               input int lr);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    write_reg(CfgOutWidth, ow);
    write_reg(CfgOutHeight, oh);
    write_reg(CfgSrcWidth, sw);
    write_reg(CfgSrcHeight, sh);
    write_reg(CfgLensRadius, lr);
    cur_ow = ow;
    cur_oh = oh;
  endtask

  // A burst of random pixels: most land inside the output image, the rest
  // anywhere in the 10-bit range so that every input bit toggles.
  task automatic random_pixels(input int count);
    int xmax, ymax;
    bit calm;
    xmax = (cur_ow < 1) ? 0 : ((cur_ow > 1024) ? 1023 : cur_ow - 1);
    ymax = (cur_oh < 1) ? 0 : ((cur_oh > 1024) ? 1023 : cur_oh - 1);
    for (int i = 0; i < count; i++) begin
      calm = (sent >= 350 && sent < 480);
      if ($urandom_range(0, 9) < 7)
        send_pixel($urandom_range(0, xmax), $urandom_range(0, ymax), !calm);
      else
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), !calm);
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    item     <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgOutWidth;
    cfg_data <= '0;
    sent     = 0;
    cur_ow   = 1000;
    cur_oh   = 1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels on the reset geometry: the exact centre, the corners,
    // the axes through the centre, and pixels far outside the output image
    // so the sine wraps past its first quarter.
    send_pixel(500, 500, 1'b0);
    send_pixel(0, 0, 1'b0);
    send_pixel(999, 0, 1'b0);
    send_pixel(0, 999, 1'b0);
    send_pixel(999, 999, 1'b0);
    send_pixel(1023, 1023, 1'b0);
    send_pixel(500, 0, 1'b0);
    send_pixel(0, 500, 1'b0);
    send_pixel(1023, 500, 1'b0);
    send_pixel(500, 1023, 1'b0);
    send_pixel(501, 500, 1'b0);
    send_pixel(500, 499, 1'b0);
    send_pixel(1023, 0, 1'b0);
    send_pixel(0, 1023, 1'b0);

    // A lens wider than the source forces clamping on both edges.
    load_geometry(1000, 1000, 717, 717, 1023);
    send_pixel(0, 500, 1'b0);
    send_pixel(999, 500, 1'b0);
    send_pixel(500, 0, 1'b0);
    send_pixel(500, 999, 1'b0);
    // Zero output sizes give a zero diagonal; zero source sizes clamp to 0.
    load_geometry(0, 0, 0, 0, 0);
    send_pixel(0, 0, 1'b0);
    send_pixel(3, 7, 1'b0);
    send_pixel(1023, 1023, 1'b0);
    send_pixel(512, 0, 1'b0);

    load_geometry(1000, 1000, 717, 717, 350);
    random_pixels(110);
    load_geometry(2, 2, 2, 2, 1);
    random_pixels(90);
    load_geometry(1024, 1024, 1024, 1024, 512);
    random_pixels(110);
    load_geometry(2047, 2047, 2047, 2047, 1023);
    random_pixels(100);
    load_geometry(640, 480, 1000, 800, 400);
    random_pixels(110);
    for (int k = 0; k < 3; k++) begin
      load_geometry($urandom_range(2, 1024), $urandom_range(2, 1024),
                    $urandom_range(2, 1024), $urandom_range(2, 1024),
                    $urandom_range(1, 512));
      random_pixels(110);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
